@@ hdl/kas_pkg.sv @@
// Package for the kinematic arrive step core: widths, reset values, codes, state type.
`timescale 1ns / 1ps

package kas_pkg;

    // Fraction bits of position and velocity words
    localparam int FRAC_BITS = 12;

    localparam int POS_W   = 24;
    localparam int LIM_W   = 23;
    localparam int TTT_W   = 16;
    localparam int DT_W    = 16;
    localparam int ACC_W   = 64;
    localparam int OPND_W  = 32;

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = 7;

    localparam logic [POS_W-1:0] POS_RESET       = POS_W'(50 << FRAC_BITS);
    localparam logic [LIM_W-1:0] MAX_SPEED_RESET = LIM_W'(100 << FRAC_BITS);
    localparam logic [LIM_W-1:0] RADIUS_RESET    = LIM_W'(5 << FRAC_BITS);
    localparam logic [TTT_W-1:0] TTT_RESET       = TTT_W'(256);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_SPEED      = 2'd0,
        CFG_ARRIVE_RADIUS  = 2'd1,
        CFG_TIME_TO_TARGET = 2'd2
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_D2X,
        ST_D2Y,
        ST_R2,
        ST_ARR,
        ST_DIV_SX,
        ST_DIV_SY,
        ST_CL_HALF,
        ST_CL_SQX,
        ST_CL_SQY,
        ST_CL_LIM,
        ST_CL_CMP,
        ST_SQRT,
        ST_CL_MX,
        ST_CL_LDX,
        ST_DIV_CX,
        ST_CL_MY,
        ST_CL_LDY,
        ST_DIV_CY,
        ST_CL_END,
        ST_VSX,
        ST_VSY,
        ST_VADDY,
        ST_PSX,
        ST_PSY,
        ST_PDY,
        ST_DONE
    } state_t;

endpackage

@@ hdl/kinematic_arrive_step_core.sv @@
// Kinematic arrive steering core: one agent, one tick per input word.
//
// Input channel s_*: one word per tick carries the target position and the
// time step. The core latches it, then runs a sequencer over one shared
// 32x32 multiplier, one restoring divider (one quotient bit per cycle,
// 64 steps) and one square-root unit (32 steps).
// Output channel m_*: one word per tick with new position and velocity;
// the arrival flag travels on m_tuser.
// The sequencer runs two steering divides unless the agent has arrived,
// then a length clamp (a square root and two divides) where the length
// exceeds the limit, once for the steering and once for the velocity.
// s_tready is high only while the sequencer idles.
// A finished word waits in the output register while the next tick is
// accepted and computed; the sequencer holds in its last state until the
// previous word has been taken, so a stalled receiver stalls the core.
// Reset (rst_n low, asynchronous) puts the agent at (50, 50) with zero
// velocity, loads the register defaults and empties the output register.
// Configuration writes (cfg_we) take effect at once; write only while idle.
`timescale 1ns / 1ps

module kinematic_arrive_step_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [22:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // target_x[23:0], target_y[47:24], time_step[63:48]
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // pos_x[23:0], pos_y[47:24], vel_x[71:48], vel_y[95:72]
    output logic        m_tuser    // arrived[0]
);

    localparam int PW = kas_pkg::POS_W;
    localparam int AW = kas_pkg::ACC_W;
    localparam int OW = kas_pkg::OPND_W;
    localparam int CW = kas_pkg::CNT_W;

    // Apply a sign to a 24-bit magnitude
    function automatic logic signed [PW:0] apply_sign(input logic [PW-1:0] m, input logic neg);
        logic signed [PW:0] v;
        v = $signed({1'b0, m});
        return neg ? -v : v;
    endfunction

    // Saturate a wide sum to a 24-bit position
    function automatic logic signed [PW-1:0] sat_pos(input logic signed [PW+1:0] v);
        logic signed [PW+1:0] hi;
        logic signed [PW+1:0] lo;
        hi = (PW+2)'(2**(PW-1) - 1);
        lo = -(PW+2)'(2**(PW-1));
        if (v > hi)
            return PW'(hi);
        else if (v < lo)
            return PW'(lo);
        else
            return v[PW-1:0];
    endfunction

    kas_pkg::state_t state_reg;
    kas_pkg::state_t state_next;

    // Configuration
    logic [kas_pkg::LIM_W-1:0] max_speed_reg;
    logic [kas_pkg::LIM_W-1:0] radius_reg;
    logic [kas_pkg::TTT_W-1:0] ttt_reg;

    // Agent state
    logic signed [PW-1:0] pos_x_reg;
    logic signed [PW-1:0] pos_y_reg;
    logic signed [PW-1:0] vel_x_reg;
    logic signed [PW-1:0] vel_y_reg;

    // Working registers
    logic [kas_pkg::DT_W-1:0] dt_reg;
    logic [PW-1:0]            dxm_reg;
    logic [PW-1:0]            dym_reg;
    logic                     dxn_reg;
    logic                     dyn_reg;
    logic                     arrived_reg;
    logic                     kind_vel_reg;
    logic [OW-1:0]            cx_reg;
    logic [OW-1:0]            cy_reg;
    logic                     nx_reg;
    logic                     ny_reg;
    logic [OW-1:0]            qx_reg;
    logic signed [PW:0]       vxs_reg;
    logic [AW-1:0]            acc_reg;
    logic [AW-1:0]            prod_reg;
    logic [CW-1:0]            cnt_reg;

    // Divider registers: dividend shifts out, quotient shifts in
    logic [AW-1:0] num_reg;
    logic [OW-1:0] rem_reg;
    logic [OW-1:0] den_reg;

    // Square-root registers (radicand is acc_reg)
    logic [AW-1:0] res_reg;
    logic [AW-1:0] bit_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic [OW-1:0] mul_a;
    logic [OW-1:0] mul_b;
    logic [AW-1:0] mul_prod;
    logic          step_last;
    logic          out_free;

    // Input word fields and target offset
    logic signed [PW-1:0] tgt_x;
    logic signed [PW-1:0] tgt_y;
    logic signed [PW:0]   dx;
    logic signed [PW:0]   dy;

    assign tgt_x = $signed(s_tdata[23:0]);
    assign tgt_y = $signed(s_tdata[47:24]);
    assign dx    = PW'(0) + ({tgt_x[PW-1], tgt_x} - {pos_x_reg[PW-1], pos_x_reg});
    assign dy    = PW'(0) + ({tgt_y[PW-1], tgt_y} - {pos_y_reg[PW-1], pos_y_reg});

    // Shared multiplier
    assign mul_prod = AW'(mul_a) * AW'(mul_b);

    // Divider step
    logic [OW:0]   div_sh;
    logic          div_ge;
    logic [OW-1:0] rem_step;
    logic [AW-1:0] num_step;

    assign div_sh   = {rem_reg, num_reg[AW-1]};
    assign div_ge   = div_sh >= {1'b0, den_reg};
    assign rem_step = div_ge ? OW'(div_sh - {1'b0, den_reg}) : div_sh[OW-1:0];
    assign num_step = {num_reg[AW-2:0], div_ge};

    // Square-root step
    logic [AW-1:0] sq_t;
    logic          sq_ge;
    logic [AW-1:0] n_step;
    logic [AW-1:0] res_step;

    assign sq_t     = res_reg + bit_reg;
    assign sq_ge    = acc_reg >= sq_t;
    assign n_step   = sq_ge ? acc_reg - sq_t : acc_reg;
    assign res_step = sq_ge ? (res_reg >> 1) + bit_reg : res_reg >> 1;

    assign step_last = cnt_reg == CW'(1);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Scaled magnitude (value * time step >> 16) from the product register
    logic [PW-1:0]          scaled;
    logic signed [PW:0]     vys;
    logic [PW:0]            vxs_mag;
    logic [PW:0]            vys_mag;
    logic signed [PW+1:0]   pos_sum_x;
    logic signed [PW+1:0]   pos_sum_y;

    assign scaled    = prod_reg[kas_pkg::DT_W +: PW];
    assign vys       = {vel_y_reg[PW-1], vel_y_reg} + apply_sign(scaled, ny_reg);
    assign vxs_mag   = vxs_reg[PW] ? PW'(0) + (PW+1)'(-vxs_reg) : vxs_reg;
    assign vys_mag   = vys[PW] ? PW'(0) + (PW+1)'(-vys) : vys;
    assign pos_sum_x = {{2{pos_x_reg[PW-1]}}, pos_x_reg} + (PW+2)'(apply_sign(scaled, nx_reg));
    assign pos_sum_y = {{2{pos_y_reg[PW-1]}}, pos_y_reg} + (PW+2)'(apply_sign(scaled, ny_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kas_pkg::ST_IDLE:    if (s_tvalid) state_next = kas_pkg::ST_D2X;
            kas_pkg::ST_D2X:     state_next = kas_pkg::ST_D2Y;
            kas_pkg::ST_D2Y:     state_next = kas_pkg::ST_R2;
            kas_pkg::ST_R2:      state_next = kas_pkg::ST_ARR;
            kas_pkg::ST_ARR:     state_next = (acc_reg <= prod_reg) ? kas_pkg::ST_VSX
                                                                   : kas_pkg::ST_DIV_SX;
            kas_pkg::ST_DIV_SX:  if (step_last) state_next = kas_pkg::ST_DIV_SY;
            kas_pkg::ST_DIV_SY:  if (step_last) state_next = kas_pkg::ST_CL_HALF;
            kas_pkg::ST_CL_HALF: if (!(cx_reg[OW-1] || cy_reg[OW-1]))
                                     state_next = kas_pkg::ST_CL_SQX;
            kas_pkg::ST_CL_SQX:  state_next = kas_pkg::ST_CL_SQY;
            kas_pkg::ST_CL_SQY:  state_next = kas_pkg::ST_CL_LIM;
            kas_pkg::ST_CL_LIM:  state_next = kas_pkg::ST_CL_CMP;
            kas_pkg::ST_CL_CMP:  state_next = (acc_reg <= prod_reg) ? kas_pkg::ST_CL_END
                                                                   : kas_pkg::ST_SQRT;
            kas_pkg::ST_SQRT:    if (step_last) state_next = kas_pkg::ST_CL_MX;
            kas_pkg::ST_CL_MX:   state_next = kas_pkg::ST_CL_LDX;
            kas_pkg::ST_CL_LDX:  state_next = kas_pkg::ST_DIV_CX;
            kas_pkg::ST_DIV_CX:  if (step_last) state_next = kas_pkg::ST_CL_MY;
            kas_pkg::ST_CL_MY:   state_next = kas_pkg::ST_CL_LDY;
            kas_pkg::ST_CL_LDY:  state_next = kas_pkg::ST_DIV_CY;
            kas_pkg::ST_DIV_CY:  if (step_last) state_next = kas_pkg::ST_CL_END;
            kas_pkg::ST_CL_END:  state_next = kind_vel_reg ? kas_pkg::ST_PSX : kas_pkg::ST_VSX;
            kas_pkg::ST_VSX:     state_next = kas_pkg::ST_VSY;
            kas_pkg::ST_VSY:     state_next = kas_pkg::ST_VADDY;
            kas_pkg::ST_VADDY:   state_next = kas_pkg::ST_CL_HALF;
            kas_pkg::ST_PSX:     state_next = kas_pkg::ST_PSY;
            kas_pkg::ST_PSY:     state_next = kas_pkg::ST_PDY;
            kas_pkg::ST_PDY:     state_next = kas_pkg::ST_DONE;
            kas_pkg::ST_DONE:    if (out_free) state_next = kas_pkg::ST_IDLE;
            default:             state_next = kas_pkg::ST_IDLE;
        endcase
    end

    // Outputs: handshake and multiplier operand selection
    always_comb
    begin
        s_tready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            kas_pkg::ST_IDLE:   s_tready = 1'b1;
            kas_pkg::ST_D2X:    begin mul_a = OW'(dxm_reg); mul_b = OW'(dxm_reg); end
            kas_pkg::ST_D2Y:    begin mul_a = OW'(dym_reg); mul_b = OW'(dym_reg); end
            kas_pkg::ST_R2:     begin mul_a = OW'(radius_reg); mul_b = OW'(radius_reg); end
            kas_pkg::ST_CL_SQX: begin mul_a = cx_reg; mul_b = cx_reg; end
            kas_pkg::ST_CL_SQY: begin mul_a = cy_reg; mul_b = cy_reg; end
            kas_pkg::ST_CL_LIM: begin mul_a = OW'(max_speed_reg); mul_b = OW'(max_speed_reg); end
            kas_pkg::ST_CL_MX:  begin mul_a = cx_reg; mul_b = OW'(max_speed_reg); end
            kas_pkg::ST_CL_MY:  begin mul_a = cy_reg; mul_b = OW'(max_speed_reg); end
            kas_pkg::ST_VSX,
            kas_pkg::ST_PSX:    begin mul_a = cx_reg; mul_b = OW'(dt_reg); end
            kas_pkg::ST_VSY,
            kas_pkg::ST_PSY:    begin mul_a = cy_reg; mul_b = OW'(dt_reg); end
            default:            ;
        endcase
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= kas_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= kas_pkg::MAX_SPEED_RESET;
            radius_reg    <= kas_pkg::RADIUS_RESET;
            ttt_reg       <= kas_pkg::TTT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (kas_pkg::cfg_index_t'(cfg_index))
                kas_pkg::CFG_MAX_SPEED:      max_speed_reg <= cfg_data;
                kas_pkg::CFG_ARRIVE_RADIUS:  radius_reg    <= cfg_data;
                kas_pkg::CFG_TIME_TO_TARGET: ttt_reg       <= cfg_data[kas_pkg::TTT_W-1:0];
                default:                     ;
            endcase
        end
    end

    // Agent state: velocity and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= kas_pkg::POS_RESET;
            pos_y_reg <= kas_pkg::POS_RESET;
            vel_x_reg <= '0;
            vel_y_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                kas_pkg::ST_ARR:
                    if (acc_reg <= prod_reg)
                    begin
                        vel_x_reg <= '0;
                        vel_y_reg <= '0;
                    end
                kas_pkg::ST_CL_END:
                    if (kind_vel_reg)
                    begin
                        vel_x_reg <= PW'(apply_sign(cx_reg[PW-1:0], nx_reg));
                        vel_y_reg <= PW'(apply_sign(cy_reg[PW-1:0], ny_reg));
                    end
                kas_pkg::ST_PSY: pos_x_reg <= sat_pos(pos_sum_x);
                kas_pkg::ST_PDY: pos_y_reg <= sat_pos(pos_sum_y);
                default:         ;
            endcase
        end
    end

    // Datapath: multiplier result, accumulator, divider, square root
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_prod;
        unique case (state_reg)
            kas_pkg::ST_IDLE:
                if (s_tvalid)
                begin
                    dt_reg  <= s_tdata[63:48];
                    dxn_reg <= dx[PW];
                    dyn_reg <= dy[PW];
                    dxm_reg <= PW'(dx[PW] ? -dx : dx);
                    dym_reg <= PW'(dy[PW] ? -dy : dy);
                end
            kas_pkg::ST_D2Y:
                acc_reg <= prod_reg;
            kas_pkg::ST_R2:
                acc_reg <= acc_reg + prod_reg;
            kas_pkg::ST_ARR:
            begin
                arrived_reg  <= acc_reg <= prod_reg;
                kind_vel_reg <= 1'b0;
                cx_reg       <= '0;
                cy_reg       <= '0;
                nx_reg       <= 1'b0;
                ny_reg       <= 1'b0;
                num_reg      <= AW'({dxm_reg, 8'b0});
                rem_reg      <= '0;
                den_reg      <= (ttt_reg == '0) ? OW'(1) : OW'(ttt_reg);
                cnt_reg      <= CW'(kas_pkg::DIV_STEPS);
            end
            kas_pkg::ST_DIV_SX:
                if (step_last)
                begin
                    cx_reg  <= num_step[OW-1:0];
                    nx_reg  <= dxn_reg;
                    num_reg <= AW'({dym_reg, 8'b0});
                    rem_reg <= '0;
                    cnt_reg <= CW'(kas_pkg::DIV_STEPS);
                end
                else
                begin
                    num_reg <= num_step;
                    rem_reg <= rem_step;
                    cnt_reg <= cnt_reg - CW'(1);
                end
            kas_pkg::ST_DIV_SY:
                if (step_last)
                begin
                    cy_reg <= num_step[OW-1:0];
                    ny_reg <= dyn_reg;
                end
                else
                begin
                    num_reg <= num_step;
                    rem_reg <= rem_step;
                    cnt_reg <= cnt_reg - CW'(1);
                end
            kas_pkg::ST_CL_HALF:
                if (cx_reg[OW-1] || cy_reg[OW-1])
                begin
                    cx_reg <= cx_reg >> 1;
                    cy_reg <= cy_reg >> 1;
                end
            kas_pkg::ST_CL_SQY:
                acc_reg <= prod_reg;
            kas_pkg::ST_CL_LIM:
                acc_reg <= acc_reg + prod_reg;
            kas_pkg::ST_CL_CMP:
            begin
                res_reg <= '0;
                bit_reg <= AW'(1) << (AW - 2);
                cnt_reg <= CW'(kas_pkg::SQRT_STEPS);
            end
            kas_pkg::ST_SQRT:
            begin
                acc_reg <= n_step;
                res_reg <= res_step;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - CW'(1);
                if (step_last)
                    den_reg <= (res_step[OW-1:0] == '0) ? OW'(1) : res_step[OW-1:0];
            end
            kas_pkg::ST_CL_LDX,
            kas_pkg::ST_CL_LDY:
            begin
                num_reg <= prod_reg;
                rem_reg <= '0;
                cnt_reg <= CW'(kas_pkg::DIV_STEPS);
            end
            kas_pkg::ST_DIV_CX:
            begin
                num_reg <= num_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg - CW'(1);
                if (step_last)
                    qx_reg <= num_step[OW-1:0];
            end
            kas_pkg::ST_DIV_CY:
            begin
                num_reg <= num_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg - CW'(1);
                if (step_last)
                begin
                    cx_reg <= qx_reg;
                    cy_reg <= num_step[OW-1:0];
                end
            end
            kas_pkg::ST_VSY:
                vxs_reg <= {vel_x_reg[PW-1], vel_x_reg} + apply_sign(scaled, nx_reg);
            kas_pkg::ST_VADDY:
            begin
                cx_reg       <= OW'(vxs_mag);
                nx_reg       <= vxs_reg[PW];
                cy_reg       <= OW'(vys_mag);
                ny_reg       <= vys[PW];
                kind_vel_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    // Output register: load when the previous word has gone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (state_reg == kas_pkg::ST_DONE && out_free)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == kas_pkg::ST_DONE && out_free)
        begin
            m_tdata_reg <= {vel_y_reg, vel_x_reg, pos_y_reg, pos_x_reg};
            m_tuser_reg <= arrived_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // An accepted tick keeps the input side closed on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a tick is in progress");

    // A new result word appears only from the final sequencer state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == kas_pkg::ST_DONE)
        else $error("result word raised outside the final state");

    // An arrival result always carries zero velocity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[95:48] == '0)
        else $error("arrived word with non-zero velocity");

    // Square-root and clamp divider states never run with an exhausted step count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kas_pkg::ST_SQRT || state_reg == kas_pkg::ST_DIV_CX
         || state_reg == kas_pkg::ST_DIV_CY) |-> cnt_reg != '0)
        else $error("iterative unit running with zero step count");

endmodule
